@@ src/nth_delimiter_match_finder_defines.svh @@
// Assertion macros for the nth-delimiter match finder.
// Each macro expects clk and arst_n in the scope where it is used.
`ifndef NTH_DELIMITER_MATCH_FINDER_DEFINES_SVH
`define NTH_DELIMITER_MATCH_FINDER_DEFINES_SVH

// Check a condition in the same cycle as its trigger.
`define NDMF_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check a condition in the cycle after its trigger.
`define NDMF_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ src/ndmf_pkg.sv @@
// Shared types, codes and defaults for the nth-delimiter match finder.
// No dependencies.
package ndmf_pkg;

	localparam int MAX_DELIMITER_BYTES_DEF = 8;
	localparam int HIT_RING_DEPTH_DEF      = 256;
	localparam int POSITION_BITS_DEF       = 16;

	localparam int CFG_DATA_W  = 64;
	localparam int CFG_INDEX_W = 3;

	// Output request queue
	localparam int OUTQ_DEPTH = 4;
	localparam int OUTQ_AW    = 2;

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_DELIM_BYTES = 3'd0,
		CFG_DELIM_LEN   = 3'd1,
		CFG_INSTANCE    = 3'd2,
		CFG_IGNORE_CASE = 3'd3,
		CFG_ENDS_COUNT  = 3'd4
	} cfg_reg_t;

	typedef enum logic [1:0] {
		STATUS_FOUND     = 2'd0,
		STATUS_NOT_FOUND = 2'd1,
		STATUS_BAD_ARGS  = 2'd2,
		STATUS_TOO_LONG  = 2'd3
	} status_t;

	// Where the reported range comes from
	typedef enum logic [1:0] {
		PICK_NONE = 2'd0,	// (0,0): no match, or text start
		PICK_END  = 2'd1,	// (n,n): text end
		PICK_FWD  = 2'd2,	// forward pick register
		PICK_RING = 2'd3	// hit start ring
	} pick_t;

	// ASCII A-Z to a-z when folding is on
	function automatic logic [7:0] fold_byte(input logic [7:0] c, input logic icase);
		if (icase && c >= 8'h41 && c <= 8'h5A) begin
			return c + 8'h20;
		end
		return c;
	endfunction

endpackage

@@ src/nth_delimiter_match_finder.sv @@
// A result passes through s1, s2 and the output queue after its final request is accepted;
// its tvalid rises once it stands in the output queue.
// Throughput: one request per cycle; input holds off only while four results sit in s1,
// s2 and the output queue. A text's ring read comes in the cycle after its last write.
// Reset (arst_n, asynchronous, active low) clears counters, pipeline and queue; the hit ring
// is not cleared and no clearing pass runs. Depends on ndmf_pkg and the defines header.
`include "nth_delimiter_match_finder_defines.svh"

module nth_delimiter_match_finder #(
	parameter int MAX_DELIMITER_BYTES = ndmf_pkg::MAX_DELIMITER_BYTES_DEF,
	parameter int HIT_RING_DEPTH      = ndmf_pkg::HIT_RING_DEPTH_DEF,
	parameter int POSITION_BITS       = ndmf_pkg::POSITION_BITS_DEF,
	localparam int OUT_W = ((2 * POSITION_BITS + 7) / 8) * 8
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// configuration write port
	input  logic                               cfg_we,
	input  logic [ndmf_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [ndmf_pkg::CFG_DATA_W-1:0]    cfg_data,
	// text stream in
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	input  logic [7:0]                         s_axis_tdata,  // text_byte
	input  logic                               s_axis_tuser,  // byte_present
	input  logic                               s_axis_tlast,  // final_byte
	// result stream out
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	output logic [OUT_W-1:0]                   m_axis_tdata,  // start offset, end offset, zero pad
	output logic [1:0]                         m_axis_tuser   // status
);

	localparam int P      = POSITION_BITS;
	localparam int MAXD   = MAX_DELIMITER_BYTES;
	localparam int D      = HIT_RING_DEPTH;
	localparam int AW     = $clog2(D);
	localparam int RW     = (AW + 1 > 9) ? AW + 1 : 9;
	localparam int TW     = P + 2;
	localparam logic [P:0] POS_MAX = {1'b0, {P{1'b1}}};

	// ------------------------------------------------------------------
	// Configuration registers
	// ------------------------------------------------------------------
	logic [ndmf_pkg::CFG_DATA_W-1:0] delim_q;
	logic [3:0]                      len_q;
	logic [8:0]                      inst_q;	// two's complement
	logic                            icase_q;
	logic                            ends_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delim_q <= '0;
			len_q   <= '0;
			inst_q  <= 9'd1;
			icase_q <= 1'b0;
			ends_q  <= 1'b0;
		end else if (cfg_we) begin
			unique case (ndmf_pkg::cfg_reg_t'(cfg_index))
				ndmf_pkg::CFG_DELIM_BYTES: delim_q <= cfg_data;
				ndmf_pkg::CFG_DELIM_LEN:   len_q   <= cfg_data[3:0];
				ndmf_pkg::CFG_INSTANCE:    inst_q  <= cfg_data[8:0];
				ndmf_pkg::CFG_IGNORE_CASE: icase_q <= cfg_data[0];
				ndmf_pkg::CFG_ENDS_COUNT:  ends_q  <= cfg_data[0];
				default: ;	// indexes beyond the register list are dropped
			endcase
		end
	end

	logic len_ok;
	logic inst_pos;
	assign len_ok   = (len_q != 4'd0) && (len_q <= 4'(MAXD));
	assign inst_pos = !inst_q[8] && (inst_q != 9'd0);

	// ------------------------------------------------------------------
	// Input side: per-byte window compare and counters
	// ------------------------------------------------------------------
	logic accept_in;
	logic take_byte;
	logic accept_fin;
	assign accept_in  = s_axis_tvalid && s_axis_tready;
	assign take_byte  = accept_in && s_axis_tuser;
	assign accept_fin = accept_in && s_axis_tlast;

	logic [7:0]    win_q [MAXD];	// newest byte at index 0
	logic [7:0]    win_n [MAXD];
	logic [7:0]    fw    [MAXD];
	logic [7:0]    fd    [MAXD];
	logic [P:0]    pos_q, eas_q, hc_q;
	logic [AW-1:0] wp_q;
	logic          fv_q;
	logic [P-1:0]  fs_q;

	logic          at_limit;
	logic [P:0]    pos_inc;
	logic [P:0]    start_w;
	logic          eq;
	logic          hit;
	logic          fwd_hit;
	logic [8:0]    fwd_tgt;

	logic [P:0]    pos_nx, eas_nx, hc_nx;
	logic [AW-1:0] wp_nx;
	logic          fv_nx;
	logic [P-1:0]  fs_nx;

	assign at_limit = pos_q >= POS_MAX;
	assign pos_inc  = pos_q + 1'b1;
	assign start_w  = pos_inc - (P + 1)'(len_q);
	assign fwd_tgt  = inst_q - 9'd1 - {8'd0, ends_q};

	// Shift the new byte in and fold both sides once
	always_comb begin
		win_n[0] = s_axis_tdata;
		for (int k = 1; k < MAXD; k++) begin
			win_n[k] = win_q[k-1];
		end
		for (int k = 0; k < MAXD; k++) begin
			fw[k] = ndmf_pkg::fold_byte(win_n[k], icase_q);
			fd[k] = ndmf_pkg::fold_byte(delim_q[8*k +: 8], icase_q);
		end
	end

	// For each possible length L, delimiter byte i lines up with window byte L-1-i;
	// keep only the compare for the configured length.
	always_comb begin
		logic eq_l;
		eq = 1'b0;
		for (int l = 1; l <= MAXD; l++) begin
			eq_l = 1'b1;
			for (int i = 0; i < l; i++) begin
				if (fd[i] != fw[l-1-i]) begin
					eq_l = 1'b0;
				end
			end
			if (len_q == 4'(l) && eq_l) begin
				eq = 1'b1;
			end
		end
	end

	// Leftmost, non-overlapping: a hit may not start before the end of the last one
	assign hit = take_byte && !at_limit && len_ok && (pos_inc >= (P + 1)'(len_q))
		&& eq && (start_w >= eas_q);
	assign fwd_hit = hit && inst_pos && (inst_q >= 9'd1 + {8'd0, ends_q})
		&& ((P + 1)'(fwd_tgt) == hc_q);

	always_comb begin
		pos_nx = pos_q;
		eas_nx = eas_q;
		hc_nx  = hc_q;
		wp_nx  = wp_q;
		fv_nx  = fv_q;
		fs_nx  = fs_q;
		if (take_byte) begin
			// Past the position range: park on the overflow mark
			pos_nx = at_limit ? POS_MAX + 1'b1 : pos_inc;
		end
		if (hit) begin
			hc_nx  = hc_q + 1'b1;
			eas_nx = pos_inc;
			wp_nx  = (wp_q == AW'(D - 1)) ? '0 : wp_q + 1'b1;
		end
		if (fwd_hit) begin
			fv_nx = 1'b1;
			fs_nx = start_w[P-1:0];
		end
	end

	// Text state; a final item hands its updated state to s1 and starts a fresh text
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			eas_q <= '0;
			hc_q  <= '0;
			wp_q  <= '0;
			fv_q  <= 1'b0;
		end else if (accept_fin) begin
			pos_q <= '0;
			eas_q <= '0;
			hc_q  <= '0;
			wp_q  <= '0;
			fv_q  <= 1'b0;
		end else if (accept_in) begin
			pos_q <= pos_nx;
			eas_q <= eas_nx;
			hc_q  <= hc_nx;
			wp_q  <= wp_nx;
			fv_q  <= fv_nx;
		end
	end

	always_ff @(posedge clk) begin
		if (take_byte && !at_limit) begin
			for (int k = 0; k < MAXD; k++) begin
				win_q[k] <= win_n[k];
			end
		end
		if (fwd_hit) begin
			fs_q <= start_w[P-1:0];
		end
	end

	// ------------------------------------------------------------------
	// s1: conclude the text and issue the ring read
	// ------------------------------------------------------------------
	logic          s1_v;
	logic [P:0]    n_s1, hc_s1;
	logic          fv_s1;
	logic [P-1:0]  fs_s1;
	logic [AW-1:0] wp_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v <= 1'b0;
		end else begin
			s1_v <= accept_fin;
		end
	end

	always_ff @(posedge clk) begin
		if (accept_fin) begin
			n_s1  <= pos_nx;
			hc_s1 <= hc_nx;
			fv_s1 <= fv_nx;
			fs_s1 <= fs_nx;
			wp_s1 <= wp_nx;
		end
	end

	logic [TW-1:0]       total;
	logic [8:0]          kmag;
	logic [RW-1:0]       back_dist;
	logic [RW-1:0]       raddr_w;
	logic                reach;
	logic [AW-1:0]       raddr_s1;
	ndmf_pkg::status_t   status_c;
	ndmf_pkg::pick_t     pick_c;

	assign total = TW'(hc_s1) + TW'({ends_q, 1'b0});
	assign kmag  = ~inst_q + 9'd1;
	// Counting back k matches with ends counted skips the virtual end match,
	// so the wanted hit sits k-e entries behind the write pointer.
	assign back_dist = RW'(kmag) - RW'(ends_q);
	assign reach     = back_dist <= RW'(D);

	always_comb begin
		if (RW'(wp_s1) >= back_dist) begin
			raddr_w = RW'(wp_s1) - back_dist;
		end else begin
			raddr_w = RW'(wp_s1) + RW'(D) - back_dist;
		end
	end
	assign raddr_s1 = raddr_w[AW-1:0];

	always_comb begin
		status_c = ndmf_pkg::STATUS_NOT_FOUND;
		pick_c   = ndmf_pkg::PICK_NONE;
		if (!len_ok || inst_q == 9'd0) begin
			status_c = ndmf_pkg::STATUS_BAD_ARGS;
		end else if (n_s1[P]) begin
			status_c = ndmf_pkg::STATUS_TOO_LONG;
		end else if (!inst_q[8]) begin
			if (TW'(inst_q) <= total) begin
				if (ends_q && inst_q == 9'd1) begin
					status_c = ndmf_pkg::STATUS_FOUND;
				end else if (ends_q && TW'(inst_q) == total) begin
					status_c = ndmf_pkg::STATUS_FOUND;
					pick_c   = ndmf_pkg::PICK_END;
				end else if (fv_s1) begin
					status_c = ndmf_pkg::STATUS_FOUND;
					pick_c   = ndmf_pkg::PICK_FWD;
				end
			end
		end else begin
			if (TW'(kmag) <= total) begin
				if (ends_q && TW'(kmag) == total) begin
					status_c = ndmf_pkg::STATUS_FOUND;
				end else if (ends_q && kmag == 9'd1) begin
					status_c = ndmf_pkg::STATUS_FOUND;
					pick_c   = ndmf_pkg::PICK_END;
				end else if (reach) begin
					status_c = ndmf_pkg::STATUS_FOUND;
					pick_c   = ndmf_pkg::PICK_RING;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Hit start ring: one write port (byte side), one registered read (s1).
	// The final byte's own hit is written at its accept edge, before
	// s1 reads, so no forwarding is needed. A new text may write in the same
	// cycle as the read; the read takes the old contents.
	// ------------------------------------------------------------------
	logic [P-1:0] ring_mem [D];
	logic [P-1:0] ring_rd_s2;

	always_ff @(posedge clk) begin
		ring_rd_s2 <= ring_mem[raddr_s1];
		if (hit) begin
			ring_mem[wp_q] <= start_w[P-1:0];
		end
	end

	// ------------------------------------------------------------------
	// s2: form the range
	// ------------------------------------------------------------------
	logic              s2_v;
	ndmf_pkg::status_t status_s2;
	ndmf_pkg::pick_t   pick_s2;
	logic [P-1:0]      n_s2, fs_s2;
	logic [P-1:0]      start_o, end_o;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s2_v <= 1'b0;
		end else begin
			s2_v <= s1_v;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_v) begin
			status_s2 <= status_c;
			pick_s2   <= pick_c;
			n_s2      <= n_s1[P-1:0];
			fs_s2     <= fs_s1;
		end
	end

	always_comb begin
		unique case (pick_s2)
			ndmf_pkg::PICK_NONE: start_o = '0;
			ndmf_pkg::PICK_END:  start_o = n_s2;
			ndmf_pkg::PICK_FWD:  start_o = fs_s2;
			ndmf_pkg::PICK_RING: start_o = ring_rd_s2;
			default:             start_o = '0;
		endcase
		if (pick_s2 == ndmf_pkg::PICK_FWD || pick_s2 == ndmf_pkg::PICK_RING) begin
			end_o = start_o + P'(len_q);
		end else begin
			end_o = start_o;
		end
	end

	// ------------------------------------------------------------------
	// Output request queue; ready counts results still in s1 and s2 so the
	// queue can never overflow while the input keeps flowing.
	// ------------------------------------------------------------------
	logic [1:0]                  q_status [ndmf_pkg::OUTQ_DEPTH];
	logic [P-1:0]                q_start  [ndmf_pkg::OUTQ_DEPTH];
	logic [P-1:0]                q_end    [ndmf_pkg::OUTQ_DEPTH];
	logic [ndmf_pkg::OUTQ_AW-1:0] q_head_q, q_tail_q;
	logic [ndmf_pkg::OUTQ_AW:0]   q_cnt_q;
	logic [ndmf_pkg::OUTQ_AW:0]   inflight;
	logic                         q_pop;

	assign inflight      = (ndmf_pkg::OUTQ_AW + 1)'(s1_v) + (ndmf_pkg::OUTQ_AW + 1)'(s2_v)
		+ q_cnt_q;
	assign s_axis_tready = inflight < (ndmf_pkg::OUTQ_AW + 1)'(ndmf_pkg::OUTQ_DEPTH);
	assign m_axis_tvalid = q_cnt_q != '0;
	assign q_pop         = m_axis_tvalid && m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q_head_q <= '0;
			q_tail_q <= '0;
			q_cnt_q  <= '0;
		end else begin
			if (s2_v) begin
				q_tail_q <= q_tail_q + 1'b1;
			end
			if (q_pop) begin
				q_head_q <= q_head_q + 1'b1;
			end
			if (s2_v && !q_pop) begin
				q_cnt_q <= q_cnt_q + 1'b1;
			end else if (!s2_v && q_pop) begin
				q_cnt_q <= q_cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s2_v) begin
			q_status[q_tail_q] <= status_s2;
			q_start[q_tail_q]  <= start_o;
			q_end[q_tail_q]    <= end_o;
		end
	end

	assign m_axis_tuser = q_status[q_head_q];
	assign m_axis_tdata = OUT_W'({q_end[q_head_q], q_start[q_head_q]});

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	`NDMF_ASSERT_SAME(a_no_overbook, 1'b1,
		inflight <= (ndmf_pkg::OUTQ_AW + 1)'(ndmf_pkg::OUTQ_DEPTH),
		"results in flight exceed output queue")
	`NDMF_ASSERT_NEXT(a_fin_enters_s1, accept_fin, s1_v, "final request did not reach s1")
	`NDMF_ASSERT_NEXT(a_text_cleared, accept_fin, pos_q == '0 && hc_q == '0 && !fv_q,
		"text state not cleared after final request")
	`NDMF_ASSERT_NEXT(a_s2_lands, s2_v, q_cnt_q != '0, "s2 result lost before queue")

endmodule
